// File: hw/rtl/lvr_pkg.sv
// lvr_pkg: shared widths, codes and state type of the low variance resampler
// used by low_variance_resampler and its testbench; depends on nothing else
package lvr_pkg;

  localparam int MAX_SAMPLES    = 1024;
  localparam int WEIGHT_BITS    = 16;
  localparam int IDX_W          = $clog2(MAX_SAMPLES);
  localparam int CNT_W          = IDX_W + 1;
  localparam int FACTOR_W       = 6;
  localparam int FRAC_W         = 16;
  localparam int SUM_W          = WEIGHT_BITS + IDX_W;
  localparam int TARGET_W       = SUM_W + FRAC_W;
  localparam int DEFAULT_FACTOR = 3;
  localparam int FACTOR_CAP     = 32;
  localparam int RUN_CAP        = 64;
  localparam int RUN_W          = $clog2(RUN_CAP + 1);
  localparam int CFG_IDX_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SPREAD_FACTOR = CFG_IDX_W'(1);

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_DRAW = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_ZERO_WEIGHT = 2'd1,
    STATUS_BAD_FACTOR  = 2'd2,
    STATUS_WRONG_PHASE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_DIST,
    S_DIV_CNT,
    S_SEARCH,
    S_COMPARE,
    S_EMIT,
    S_REPORT
  } lvr_state_t;

endpackage

// File: hw/rtl/lvr_ram.sv
// lvr_ram: generic single-clock ram, one write port and one registered read port
// no package dependency
module lvr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/lvr_div.sv
// lvr_div: restoring unsigned divider, one quotient bit per cycle
// no package dependency; width handed down from the top level
module lvr_div #(
  parameter int W = 11
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int STEP_W = $clog2(W + 1);

  logic              active;
  logic [STEP_W-1:0] steps;
  logic [W-1:0]      rem;
  logic [W-1:0]      quo;
  logic [W-1:0]      dvs;
  logic [W:0]        rem_shift;
  logic              fits;

  assign rem_shift = {rem, quo[W-1]};
  assign fits      = rem_shift >= {1'b0, dvs};
  assign done      = active && (steps == '0);
  assign quotient  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      steps  <= '0;
    end else if (start) begin
      active <= 1'b1;
      steps  <= STEP_W'(W);
    end else if (active) begin
      if (steps == '0) begin
        active <= 1'b0;
      end else begin
        steps <= steps - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (active && (steps != '0)) begin
      if (fits) begin
        rem <= W'(rem_shift - {1'b0, dvs});
      end else begin
        rem <= rem_shift[W-1:0];
      end
      quo <= {quo[W-2:0], fits};
    end
  end

endmodule

// File: hw/rtl/low_variance_resampler.sv
// low_variance_resampler: top level of the particle filter resampler
// uses lvr_pkg, lvr_ram (cumulative weight table) and lvr_div (spacing and run count divider)
//
// Particle filter low variance resampler. Load beats (action 0) bring one
// unnormalized weight each; the block writes the running cumulative sum into a
// 1024 x 26 table ram, and after sample_count loads it enters the draw phase. A
// draw beat (action 1) brings a 16-bit uniform fraction r; the block picks the
// first particle j with cum[j] * 65536 > r * total by a binary search over the
// table and then emits up to n/spacing indices (j + k*spacing) mod n, spacing =
// n / spread_factor, one result beat per cycle while the output is free. The
// round ends after n indices; the block then returns to loading. Draws in the
// load phase or loads in the draw phase give one result with status 3, a factor
// above n gives status 2, a zero total weight gives status 1. Before its first
// result a draw runs two divisions (spacing, then n/spacing), the search, where
// each probe costs a ram read and a compare, and then settles the pick and fills
// the result register. Items are handled one at a time; item_stall is low only
// when the block is idle. The result register lets a new item be taken while the
// last result beat still waits downstream. Any configuration write to a known
// register restarts the round; the table contents are kept.
module low_variance_resampler
  import lvr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // item channel
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic                  action,
  input  logic [15:0]           weight,
  input  logic [FRAC_W-1:0]     random_fraction,
  // result channel
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [IDX_W-1:0]      sample_index,
  output logic                  last_in_run,
  output logic                  round_done,
  output logic [1:0]            status,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CNT_W-1:0]      cfg_data
);

  lvr_state_t state, state_next;

  // configuration and round bookkeeping
  logic [CNT_W-1:0]    sample_count, sample_count_next;
  logic [FACTOR_W-1:0] spread_factor, spread_factor_next;
  logic [CNT_W-1:0]    loaded_count, loaded_count_next;
  logic [CNT_W-1:0]    emitted_count, emitted_count_next;
  logic                draw_phase, draw_phase_next;
  logic [SUM_W-1:0]    run_sum, run_sum_next;   // also the round total once loaded

  // draw datapath
  logic [FRAC_W-1:0]   frac, frac_next;
  logic [TARGET_W-1:0] target, target_next;
  logic [CNT_W-1:0]    spacing, spacing_next;
  logic [RUN_W-1:0]    run, run_next;
  logic [RUN_W-1:0]    k, k_next;
  logic [IDX_W-1:0]    lo, lo_next;
  logic [IDX_W-1:0]    hi, hi_next;
  logic [IDX_W-1:0]    pick, pick_next;
  status_t             err_status, err_status_next;

  // result register
  logic                out_valid, out_valid_next;
  logic [IDX_W-1:0]    out_index, out_index_next;
  logic                out_last, out_last_next;
  logic                out_done, out_done_next;
  status_t             out_status, out_status_next;

  // effective settings
  logic [CNT_W-1:0]    n_eff;
  logic [FACTOR_W-1:0] f_eff;

  // table ram
  logic                ram_wr_en;
  logic [IDX_W-1:0]    ram_wr_addr;
  logic [SUM_W-1:0]    ram_wr_data;
  logic                ram_rd_en;
  logic [SUM_W-1:0]    ram_rd_data;

  // divider
  logic                div_start;
  logic [CNT_W-1:0]    div_divisor;
  logic                div_done;
  logic [CNT_W-1:0]    div_quotient;

  // helpers
  logic                item_accept;
  logic                out_free;
  logic [IDX_W:0]      mid_sum;
  logic [IDX_W-1:0]    mid;
  logic [CNT_W-1:0]    remain;
  logic [CNT_W-1:0]    run_min;
  logic [CNT_W-1:0]    step_sum;
  logic [CNT_W-1:0]    step_wrap;
  logic                is_last;
  logic                is_done;
  logic                cfg_known;

  // n of zero counts as one, n above the table size saturates
  always_comb begin
    if (sample_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (sample_count > CNT_W'(MAX_SAMPLES)) begin
      n_eff = CNT_W'(MAX_SAMPLES);
    end else begin
      n_eff = sample_count;
    end
  end

  // factor of zero takes the default, large factors saturate
  always_comb begin
    if (spread_factor == '0) begin
      f_eff = FACTOR_W'(DEFAULT_FACTOR);
    end else if (spread_factor > FACTOR_W'(FACTOR_CAP)) begin
      f_eff = FACTOR_W'(FACTOR_CAP);
    end else begin
      f_eff = spread_factor;
    end
  end

  assign item_stall  = (state != S_IDLE);
  assign item_accept = item_valid && !item_stall;
  assign cfg_ready   = 1'b1;
  assign out_free    = !out_valid || !result_stall;

  // binary search probe, lowest index whose scaled sum beats the target
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[IDX_W:1];

  // run length bound by spacing count, particles left in the round and the cap
  assign remain  = n_eff - emitted_count;
  assign run_min = (div_quotient < remain) ? div_quotient : remain;

  // next index of the run, wrapped mod n (pick below n, spacing at most n)
  assign step_sum  = CNT_W'(pick) + spacing;
  assign step_wrap = (step_sum >= n_eff) ? (step_sum - n_eff) : step_sum;

  assign is_last = (k + RUN_W'(1)) == run;
  assign is_done = (emitted_count + CNT_W'(1)) >= n_eff;

  assign cfg_known = (cfg_index == REG_SAMPLE_COUNT) || (cfg_index == REG_SPREAD_FACTOR);

  always_comb begin
    state_next         = state;
    sample_count_next  = sample_count;
    spread_factor_next = spread_factor;
    loaded_count_next  = loaded_count;
    emitted_count_next = emitted_count;
    draw_phase_next    = draw_phase;
    run_sum_next       = run_sum;
    frac_next          = frac;
    target_next        = target;
    spacing_next       = spacing;
    run_next           = run;
    k_next             = k;
    lo_next            = lo;
    hi_next            = hi;
    pick_next          = pick;
    err_status_next    = err_status;
    out_valid_next     = out_valid && result_stall;
    out_index_next     = out_index;
    out_last_next      = out_last;
    out_done_next      = out_done;
    out_status_next    = out_status;

    ram_wr_en   = 1'b0;
    ram_wr_addr = loaded_count[IDX_W-1:0];
    ram_wr_data = run_sum + SUM_W'(weight);
    ram_rd_en   = 1'b0;
    div_start   = 1'b0;
    div_divisor = CNT_W'(f_eff);

    case (state)
      S_IDLE: begin
        if (item_accept) begin
          if (action == ACT_LOAD) begin
            if (draw_phase) begin
              err_status_next = STATUS_WRONG_PHASE;
              state_next      = S_REPORT;
            end else begin
              ram_wr_en         = 1'b1;
              run_sum_next      = ram_wr_data;
              loaded_count_next = loaded_count + CNT_W'(1);
              if ((loaded_count + CNT_W'(1)) >= n_eff) begin
                draw_phase_next    = 1'b1;
                emitted_count_next = '0;
              end
            end
          end else if (!draw_phase) begin
            err_status_next = STATUS_WRONG_PHASE;
            state_next      = S_REPORT;
          end else if (CNT_W'(f_eff) > n_eff) begin
            err_status_next = STATUS_BAD_FACTOR;
            state_next      = S_REPORT;
          end else if (run_sum == '0) begin
            err_status_next = STATUS_ZERO_WEIGHT;
            state_next      = S_REPORT;
          end else begin
            frac_next  = random_fraction;
            div_start  = 1'b1;
            state_next = S_DIV_DIST;
          end
        end
      end

      S_DIV_DIST: begin
        // fraction scaled by the total weight, no normalization needed
        target_next = TARGET_W'(frac) * TARGET_W'(run_sum);
        if (div_done) begin
          spacing_next = div_quotient;
          div_start    = 1'b1;
          div_divisor  = div_quotient;
          state_next   = S_DIV_CNT;
        end
      end

      S_DIV_CNT: begin
        if (div_done) begin
          if (run_min > CNT_W'(RUN_CAP)) begin
            run_next = RUN_W'(RUN_CAP);
          end else begin
            run_next = run_min[RUN_W-1:0];
          end
          lo_next    = '0;
          hi_next    = IDX_W'(n_eff - CNT_W'(1));
          state_next = S_SEARCH;
        end
      end

      S_SEARCH: begin
        if (lo == hi) begin
          pick_next  = lo;
          k_next     = '0;
          state_next = S_EMIT;
        end else begin
          ram_rd_en  = 1'b1;
          state_next = S_COMPARE;
        end
      end

      S_COMPARE: begin
        if ({ram_rd_data, FRAC_W'(0)} > target) begin
          hi_next = mid;
        end else begin
          lo_next = mid + IDX_W'(1);
        end
        state_next = S_SEARCH;
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_index_next  = pick;
          out_last_next   = is_last;
          out_done_next   = is_done;
          out_status_next = STATUS_OK;
          pick_next       = step_wrap[IDX_W-1:0];
          k_next          = k + RUN_W'(1);
          if (is_done) begin
            loaded_count_next  = '0;
            emitted_count_next = '0;
            draw_phase_next    = 1'b0;
            run_sum_next       = '0;
          end else begin
            emitted_count_next = emitted_count + CNT_W'(1);
          end
          if (is_last) begin
            state_next = S_IDLE;
          end
        end
      end

      S_REPORT: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_index_next  = '0;
          out_last_next   = 1'b1;
          out_done_next   = 1'b0;
          out_status_next = err_status;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // register write restarts the round, the table is kept
    if (cfg_valid && cfg_ready && cfg_known) begin
      if (cfg_index == REG_SAMPLE_COUNT) begin
        sample_count_next = cfg_data;
      end else begin
        spread_factor_next = cfg_data[FACTOR_W-1:0];
      end
      loaded_count_next  = '0;
      emitted_count_next = '0;
      draw_phase_next    = 1'b0;
      run_sum_next       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      sample_count  <= CNT_W'(MAX_SAMPLES);
      spread_factor <= FACTOR_W'(DEFAULT_FACTOR);
      loaded_count  <= '0;
      emitted_count <= '0;
      draw_phase    <= 1'b0;
      run_sum       <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      sample_count  <= sample_count_next;
      spread_factor <= spread_factor_next;
      loaded_count  <= loaded_count_next;
      emitted_count <= emitted_count_next;
      draw_phase    <= draw_phase_next;
      run_sum       <= run_sum_next;
      out_valid     <= out_valid_next;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    frac       <= frac_next;
    target     <= target_next;
    spacing    <= spacing_next;
    run        <= run_next;
    k          <= k_next;
    lo         <= lo_next;
    hi         <= hi_next;
    pick       <= pick_next;
    err_status <= err_status_next;
    out_index  <= out_index_next;
    out_last   <= out_last_next;
    out_done   <= out_done_next;
    out_status <= out_status_next;
  end

  assign result_valid = out_valid;
  assign sample_index = out_index;
  assign last_in_run  = out_last;
  assign round_done   = out_done;
  assign status       = out_status;

  // cumulative weight table
  lvr_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_SAMPLES)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (mid),
    .rd_data (ram_rd_data)
  );

  // spacing and run count division
  lvr_div #(
    .W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (n_eff),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

endmodule

// File: tb/low_variance_resampler_tb.sv
// low_variance_resampler_tb: self-checking bench for the particle filter resampler
// drives load and draw beats plus register writes, predicts every result beat in
// its own model of the cumulative table and round counters; needs lvr_pkg and the rtl
`timescale 1ns / 1ps

module low_variance_resampler_tb;
  import lvr_pkg::*;

  // stimulus sizing and waits
  localparam int unsigned RANDOM_ITEMS  = 230;
  localparam int unsigned EARLY_LOADS   = 40;   // loads into a saturated count round
  localparam int unsigned FULL_LOADS    = 64;   // particles of the saturated factor round
  localparam int unsigned SETTLE_CYCLES = 64;   // wait after each drain while the block settles
  localparam int unsigned ERROR_DRAWS   = 3;    // draws sent into a round that can only fail

  // register indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  logic                 clk;
  logic                 rst;
  logic                 item_valid;
  logic                 item_stall;
  logic                 action;
  logic [15:0]          weight;
  logic [FRAC_W-1:0]    random_fraction;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic [IDX_W-1:0]     sample_index;
  logic                 last_in_run;
  logic                 round_done;
  logic [1:0]           status;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CNT_W-1:0]     cfg_data;

  low_variance_resampler uut (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .action          (action),
    .weight          (weight),
    .random_fraction (random_fraction),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .sample_index    (sample_index),
    .last_in_run     (last_in_run),
    .round_done      (round_done),
    .status          (status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // resampler model: cumulative table, round counters and both registers
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             last;
    logic             done;
    status_t          code;
  } pick_t;

  pick_t            pick_q[$];            // result beats still owed by the block
  logic [SUM_W-1:0] cum_tbl[MAX_SAMPLES]; // running weight sums of this round
  int unsigned      loaded_n;
  int unsigned      emitted_n;
  bit               drawing;              // set once n weights are in
  logic [CNT_W-1:0] count_reg = CNT_W'(MAX_SAMPLES);
  logic [5:0]       factor_reg = 6'(DEFAULT_FACTOR);

  int unsigned mismatch_count = 0;
  int unsigned item_count     = 0;
  int unsigned burst_left     = 0;

  // zero count means one particle, anything above the table size saturates
  function automatic int unsigned active_count();
    if (count_reg == 0) return 1;
    if (count_reg > MAX_SAMPLES) return MAX_SAMPLES;
    return count_reg;
  endfunction

  // zero factor falls back to the default, large factors saturate
  function automatic int unsigned active_factor();
    if (factor_reg == 0) return DEFAULT_FACTOR;
    if (factor_reg > FACTOR_CAP) return FACTOR_CAP;
    return factor_reg;
  endfunction

  function automatic void restart_round();
    loaded_n  = 0;
    emitted_n = 0;
    drawing   = 1'b0;
  endfunction

  function automatic void queue_pick(int unsigned idx, bit last, bit done, status_t code);
    pick_t p;
    p.idx  = IDX_W'(idx);
    p.last = last;
    p.done = done;
    p.code = code;
    pick_q = {pick_q, p};
  endfunction

  // register write as seen at the handshake; unknown indexes leave the round alone
  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
    if (idx == REG_SAMPLE_COUNT) count_reg = data;
    else if (idx == REG_SPREAD_FACTOR) factor_reg = data[5:0];
    else return;
    restart_round();
  endfunction

  // expected result beats for one accepted item beat
  function automatic void predict_resample(logic act, logic [15:0] w, logic [FRAC_W-1:0] r);
    int unsigned         n;
    int unsigned         f;
    int unsigned         spacing;
    int unsigned         run;
    int unsigned         j;
    int unsigned         k;
    logic [SUM_W-1:0]    total;
    logic [TARGET_W-1:0] target;
    n = active_count();
    f = active_factor();
    if (act == ACT_LOAD) begin
      if (drawing) begin
        queue_pick(0, 1'b1, 1'b0, STATUS_WRONG_PHASE);
        return;
      end
      cum_tbl[loaded_n] = ((loaded_n == 0) ? SUM_W'(0) : cum_tbl[loaded_n - 1]) + SUM_W'(w);
      loaded_n++;
      if (loaded_n >= n) begin
        drawing   = 1'b1;
        emitted_n = 0;
      end
      return;
    end
    if (!drawing) begin
      queue_pick(0, 1'b1, 1'b0, STATUS_WRONG_PHASE);
      return;
    end
    // factor check comes before the zero weight check
    if (f > n) begin
      queue_pick(0, 1'b1, 1'b0, STATUS_BAD_FACTOR);
      return;
    end
    total = cum_tbl[n - 1];
    if (total == 0) begin
      queue_pick(0, 1'b1, 1'b0, STATUS_ZERO_WEIGHT);
      return;
    end
    // first entry whose sum, scaled by 2^16, beats fraction times total
    target = TARGET_W'(r) * TARGET_W'(total);
    j = n - 1;
    for (k = 0; k < n; k++) begin
      if ({cum_tbl[k], {FRAC_W{1'b0}}} > target) begin
        j = k;
        break;
      end
    end
    spacing = n / f;
    run     = n / spacing;
    if (run > n - emitted_n) run = n - emitted_n;
    if (run > RUN_CAP) run = RUN_CAP;
    for (k = 0; k < run; k++) begin
      emitted_n++;
      queue_pick((j + k * spacing) % n, k + 1 == run, emitted_n >= n, STATUS_OK);
    end
    if (emitted_n >= n) restart_round();
  endfunction

  // ---------------------------------------------------------------------------
  // result side: stall pattern and checker
  // ---------------------------------------------------------------------------
  int unsigned stall_mode = 0;
  int unsigned mode_left  = 0;

  // stall modes held for random stretches: free flow, light, heavy
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: result_stall <= 1'b0;
      1: result_stall <= ($urandom_range(0, 2) == 0);
      default: result_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic flag_mismatch(input string what);
    $display("%0t ns  mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // every accepted result beat is matched against the oldest owed one
  always @(posedge clk) begin : check_results
    pick_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pick_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result beat, index %0d status %0d",
                                sample_index, status));
      end else begin
        want = pick_q.pop_front();
        if (sample_index !== want.idx)
          flag_mismatch($sformatf("sample_index %0d, want %0d", sample_index, want.idx));
        if (last_in_run !== want.last)
          flag_mismatch($sformatf("last_in_run %0b, want %0b", last_in_run, want.last));
        if (round_done !== want.done)
          flag_mismatch($sformatf("round_done %0b, want %0b", round_done, want.done));
        if (status !== want.code)
          flag_mismatch($sformatf("status %0d, want %0d", status, want.code));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // item side: one beat at a time, in bursts with random gaps
  // ---------------------------------------------------------------------------
  // entered at a falling edge, returns at the falling edge after the handshake
  task automatic send_beat(input logic act, input logic [15:0] w, input logic [FRAC_W-1:0] r);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    item_valid      <= 1'b1;
    action          <= act;
    weight          <= w;
    random_fraction <= r;
    do @(posedge clk); while (item_stall);
    item_count++;
    predict_resample(act, w, r);
    @(negedge clk);
  endtask

  // hold off new beats until every owed result is back, then let the block settle
  task automatic drain_results();
    item_valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pick_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // only called with the block idle; cfg_valid drops again after each write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // draw straight after reset lands in the load phase
  task automatic test_phase_after_reset();
    send_beat(ACT_DRAW, 16'h0, 16'h8000);
  endtask

  // count zero means one particle; default factor 3 is then too big
  task automatic test_single_particle();
    drain_results();
    write_reg(REG_SAMPLE_COUNT, CNT_W'(0));
    send_beat(ACT_LOAD, 16'd7, 16'h0);
    send_beat(ACT_LOAD, 16'hFFFF, 16'hFFFF);   // load in the draw phase
    send_beat(ACT_DRAW, 16'h0, 16'h1234);      // factor exceeds count
    drain_results();
    write_reg(REG_SPREAD_FACTOR, CNT_W'(1));   // restarts the round
    send_beat(ACT_LOAD, 16'hFFFF, 16'h0);
    send_beat(ACT_DRAW, 16'h0, 16'hFFFF);      // one pick ends the round
    send_beat(ACT_DRAW, 16'h0, 16'h0);         // back in the load phase
  endtask

  // all weights zero, factor zero taken as the default
  task automatic test_zero_total();
    int unsigned k;
    drain_results();
    write_reg(REG_SAMPLE_COUNT, CNT_W'(4));
    write_reg(REG_SPREAD_FACTOR, CNT_W'(0));
    for (k = 0; k < 4; k++) send_beat(ACT_LOAD, 16'h0, 16'hFFFF);
    send_beat(ACT_DRAW, 16'hFFFF, 16'h4000);
  endtask

  // six particles, spacing three: fraction extremes and a midpoint, ends the round
  task automatic test_spread_draws();
    drain_results();
    write_reg(REG_SAMPLE_COUNT, CNT_W'(6));
    write_reg(REG_SPREAD_FACTOR, CNT_W'(2));
    send_beat(ACT_LOAD, 16'h0, 16'h0);
    send_beat(ACT_LOAD, 16'hFFFF, 16'h0);
    send_beat(ACT_LOAD, 16'h0, 16'h0);
    send_beat(ACT_LOAD, 16'h1, 16'h0);
    send_beat(ACT_LOAD, 16'hFFFF, 16'h0);
    send_beat(ACT_LOAD, 16'h0, 16'h0);
    send_beat(ACT_DRAW, 16'h0, 16'h0);
    send_beat(ACT_DRAW, 16'h0, 16'hFFFF);
    send_beat(ACT_DRAW, 16'h0, 16'h8000);
  endtask

  // writes to undecoded indexes must not restart a round in progress
  task automatic test_unknown_register();
    drain_results();
    write_reg(REG_SAMPLE_COUNT, CNT_W'(2));
    write_reg(REG_SPREAD_FACTOR, CNT_W'(1));
    send_beat(ACT_LOAD, 16'h00FF, 16'h0);
    send_beat(ACT_LOAD, 16'hFF00, 16'h0);
    send_beat(ACT_DRAW, 16'h0, 16'hAAAA);
    drain_results();
    write_reg(REG_SPARE_A, CNT_W'(11'h7FF));
    write_reg(REG_SPARE_B, CNT_W'(11'h555));
    send_beat(ACT_DRAW, 16'h0, 16'h5555);
  endtask

  // saturated count keeps loading past a short run; saturated factor on
  // maximum weights gives two draws of 32 picks
  task automatic test_full_scale();
    int unsigned k;
    drain_results();
    write_reg(REG_SAMPLE_COUNT, CNT_W'(11'h7FF));
    write_reg(REG_SPREAD_FACTOR, CNT_W'(63));
    for (k = 0; k < EARLY_LOADS; k++) send_beat(ACT_LOAD, 16'hFFFF, 16'($urandom));
    send_beat(ACT_DRAW, 16'($urandom), 16'h0);   // still loading
    drain_results();
    write_reg(REG_SAMPLE_COUNT, CNT_W'(FULL_LOADS));
    for (k = 0; k < FULL_LOADS; k++) send_beat(ACT_LOAD, 16'hFFFF, 16'($urandom));
    send_beat(ACT_DRAW, 16'($urandom), 16'h0);
    send_beat(ACT_DRAW, 16'($urandom), 16'hFFFF);
    while (drawing) send_beat(ACT_DRAW, 16'($urandom), 16'($urandom));
  endtask

  // random rounds: new settings, a well-formed load run, then draws to the round end,
  // with stray beats, aborted rounds and full drains mixed in
  task automatic test_random_rounds();
    int unsigned      start;
    int unsigned      n;
    int unsigned      f_raw;
    int unsigned      wmode;
    int unsigned      errs;
    int unsigned      k;
    logic [CNT_W-1:0] data;
    logic [15:0]      w;
    logic [15:0]      r;
    start = item_count;
    while (item_count - start < RANDOM_ITEMS) begin
      drain_results();
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 7))
          0: n = 0;
          1: n = $urandom_range(65, 160);
          default: n = $urandom_range(1, 48);
        endcase
        write_reg(REG_SAMPLE_COUNT, CNT_W'(n));
      end
      n = active_count();
      case ($urandom_range(0, 7))
        0: f_raw = 0;
        1: f_raw = $urandom_range(33, 63);
        2: f_raw = $urandom_range(1, 32);
        default: f_raw = $urandom_range(1, (n < FACTOR_CAP) ? n : FACTOR_CAP);
      endcase
      // upper data bits are don't-care for the factor, keep them toggling
      data      = CNT_W'($urandom);
      data[5:0] = 6'(f_raw);
      if ($urandom_range(0, 5) == 0)
        write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B, CNT_W'($urandom));
      write_reg(REG_SPREAD_FACTOR, data);

      // load run, now and then a draw that arrives too early
      wmode = $urandom_range(0, 9);
      for (k = 0; k < n; k++) begin
        if ($urandom_range(0, 19) == 0) send_beat(ACT_DRAW, 16'($urandom), 16'($urandom));
        case (wmode)
          0: w = 16'h0;
          1, 2: w = 16'($urandom_range(0, 15));
          3: w = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'h0;
          default: w = 16'($urandom);
        endcase
        send_beat(ACT_LOAD, w, 16'($urandom));
      end

      // draws until the round ends, a few if it can only fail, or an early abort
      errs = 0;
      while (drawing && errs < ERROR_DRAWS) begin
        if ($urandom_range(0, 11) == 0) send_beat(ACT_LOAD, 16'($urandom), 16'($urandom));
        if ($urandom_range(0, 14) == 0) drain_results();
        case ($urandom_range(0, 9))
          0: r = 16'h0;
          1: r = 16'hFFFF;
          default: r = 16'($urandom);
        endcase
        if (active_factor() > n || cum_tbl[n - 1] == 0) errs++;
        send_beat(ACT_DRAW, 16'($urandom), r);
        if ($urandom_range(0, 24) == 0) break;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst             = 1'b1;
    item_valid      = 1'b0;
    action          = ACT_LOAD;
    weight          = 16'h0;
    random_fraction = '0;
    cfg_valid       = 1'b0;
    cfg_index       = REG_SAMPLE_COUNT;
    cfg_data        = '0;
    restart_round();
    foreach (cum_tbl[i]) cum_tbl[i] = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_phase_after_reset();
    test_single_particle();
    test_zero_total();
    test_spread_draws();
    test_unknown_register();
    test_full_scale();
    test_random_rounds();

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pick_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hard stop, many times the slowest legal run
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: low_variance_resampler.f
hw/rtl/lvr_pkg.sv
hw/rtl/lvr_ram.sv
hw/rtl/lvr_div.sv
hw/rtl/low_variance_resampler.sv
tb/low_variance_resampler_tb.sv
